[rtl/core/utf8_sanitize_latin_fold_macros.svh]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZE_LATIN_FOLD_MACROS_SVH
`define UTF8_SANITIZE_LATIN_FOLD_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define USL_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8 sanitiser check failed");

// next-cycle implication, sampled on clock, quiet during reset
`define USL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8 sanitiser check failed");

`endif

[rtl/core/usl_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser package
// Word types, register indexes and byte classification helpers.
// ----------------------------------------------------------------------------
package usl_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_FOLD_MODE   = 2'd0;
   localparam logic [1:0] CSR_CLIP_ENABLE = 2'd1;
   localparam logic [1:0] CSR_CLIP_LIMIT  = 2'd2;

   localparam logic [7:0]  CHAR_QMARK     = 8'h3F;
   localparam logic [7:0]  LEAD_LATIN     = 8'hC3;
   localparam logic [15:0] CLIP_LIMIT_RST = 16'hFFFF;
   localparam int          QUEUE_DEPTH    = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } usl_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_done;
      logic       non_ascii_seen;
   } usl_rsp_type;

   typedef struct packed {
      logic        fold_mode;
      logic        clip_enable;
      logic [15:0] clip_limit;
   } usl_cfg_type;

   // one burst of results for one accepted byte
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;      // 1..4 results
      logic            byte_valid; // 0 for a bare end marker
      logic            string_end;
      logic            non_ascii;
   } usl_desc_type;

   // sequence length from the lead byte, 0 for a bad lead
   function automatic logic [2:0] usl_seq_len(input logic [7:0] b);
      logic [2:0] n;
      if (b[7] == 1'b0)
         n = 3'd1;
      else if ((b & 8'hE0) == 8'hC0)
         n = 3'd2;
      else if ((b & 8'hF0) == 8'hE0)
         n = 3'd3;
      else if ((b & 8'hF8) == 8'hF0)
         n = 3'd4;
      else
         n = 3'd0;
      return n;
   endfunction

   // plain letter for a C3 continuation byte, 0 where none applies
   function automatic logic [7:0] usl_fold_letter(input logic [7:0] b);
      logic [7:0] c;
      c = 8'h00;
      case (b[4:0])
         5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05: c = 8'h41; // A
         5'h07:                                    c = 8'h43; // C
         5'h08, 5'h09, 5'h0A, 5'h0B:               c = 8'h45; // E
         5'h0C, 5'h0D, 5'h0E, 5'h0F:               c = 8'h49; // I
         5'h11:                                    c = 8'h4E; // N
         5'h12, 5'h13, 5'h14, 5'h15, 5'h16:        c = 8'h4F; // O
         5'h19, 5'h1A, 5'h1B, 5'h1C:               c = 8'h55; // U
         default:                                  c = 8'h00;
      endcase
      if (b[7:6] != 2'b10)
         c = 8'h00;
      else if (c != 8'h00 && b[5])
         c = c + 8'h20;
      return c;
   endfunction

endpackage

[rtl/core/usl_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser front end
// Takes one byte a cycle while the queue is not full, tracks the open sequence,
// applies fold and clip, and hands a burst of up to four output bytes to the queue.
// ----------------------------------------------------------------------------
module usl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  usl_pkg::usl_req_type req_data,
   input  usl_pkg::usl_cfg_type cfg,
   input  logic                 q_full,
   output logic                 q_push,
   output usl_pkg::usl_desc_type q_data
);
   import usl_pkg::*;

   logic [7:0]  held_ff [3];
   logic [1:0]  hc_ff, hc_in;
   logic [2:0]  nl_ff, nl_in;
   logic        flag_ff, flag_in;
   logic [15:0] cnt_ff, cnt_in;

   logic            accept;
   logic [7:0]      b;
   logic            fin;
   logic            is_cont;
   logic [2:0]      slen;
   logic [3:0][7:0] cand;
   logic [2:0]      units;
   logic            multi;
   logic            tail;
   logic [7:0]      tail_char;
   logic [2:0]      pre;
   logic            held_we;
   logic [1:0]      held_idx;
   logic [7:0]      fold_c;
   logic            clip_act;
   logic [15:0]     avail;
   logic [2:0]      allowed;
   logic [2:0]      nb;
   logic [16:0]     cnt_sum;
   logic            flag_new;
   logic [15:0]     cnt_new;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_data.in_byte;
   assign fin       = req_data.string_end;
   assign is_cont   = (b[7:6] == 2'b10);
   assign slen      = usl_seq_len(b);
   assign fold_c    = usl_fold_letter(b);

   // sequence tracking: candidate bytes and number of units
   always_comb begin
      cand      = {4{CHAR_QMARK}};
      units     = 3'd0;
      multi     = 1'b0;
      tail      = 1'b0;
      tail_char = CHAR_QMARK;
      pre       = 3'd0;
      held_we   = 1'b0;
      held_idx  = 2'd0;
      hc_in     = 2'd0;
      nl_in     = 3'd0;
      if (hc_ff == 2'd0 || !is_cont) begin
         // new lead, after flushing any broken sequence
         pre = {1'b0, hc_ff};
         if (slen == 3'd1) begin
            tail      = 1'b1;
            tail_char = b;
         end else if (slen == 3'd0) begin
            tail = 1'b1;
         end else if (fin) begin
            tail = 1'b1;   // lead truncated at string end
         end else begin
            held_we = 1'b1;
            hc_in   = 2'd1;
            nl_in   = slen;
         end
         units = pre + {2'b00, tail};
         if (tail)
            cand[pre[1:0]] = tail_char;
      end else if ({1'b0, hc_ff} + 3'd1 == nl_ff) begin
         // sequence complete
         units = 3'd1;
         if (cfg.fold_mode && nl_ff == 3'd2 && held_ff[0] == LEAD_LATIN
             && fold_c != 8'h00) begin
            cand[0] = fold_c;
         end else begin
            multi   = 1'b1;
            cand[0] = held_ff[0];
            cand[1] = held_ff[1];
            cand[2] = held_ff[2];
            cand[hc_ff] = b;
         end
      end else begin
         // more continuation bytes to come, or a flush at string end
         held_we  = 1'b1;
         held_idx = hc_ff;
         if (fin) begin
            units = {1'b0, hc_ff} + 3'd1;
         end else begin
            hc_in = hc_ff + 2'd1;
            nl_in = nl_ff;
         end
      end
   end

   // codepoint clip and counters
   always_comb begin
      clip_act = cfg.clip_enable && !cfg.fold_mode;
      avail    = (cnt_ff >= cfg.clip_limit) ? 16'd0 : (cfg.clip_limit - cnt_ff);
      if (clip_act && avail < {13'd0, units})
         allowed = avail[2:0];
      else
         allowed = units;
      if (multi)
         nb = (allowed != 3'd0) ? nl_ff : 3'd0;
      else
         nb = allowed;
      flag_new = flag_ff || (multi && allowed != 3'd0);
      cnt_sum  = {1'b0, cnt_ff} + {14'd0, allowed};
      cnt_new  = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
      flag_in  = fin ? 1'b0 : flag_new;
      cnt_in   = fin ? 16'd0 : cnt_new;
   end

   // burst word towards the queue
   always_comb begin
      q_push            = accept && (nb != 3'd0 || fin);
      q_data.bytes      = (nb != 3'd0) ? cand : '0;
      q_data.count      = (nb != 3'd0) ? nb : 3'd1;
      q_data.byte_valid = (nb != 3'd0);
      q_data.string_end = fin;
      q_data.non_ascii  = flag_new;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff   <= 2'd0;
         nl_ff   <= 3'd0;
         flag_ff <= 1'b0;
         cnt_ff  <= 16'd0;
      end else if (accept) begin
         hc_ff   <= hc_in;
         nl_ff   <= nl_in;
         flag_ff <= flag_in;
         cnt_ff  <= cnt_in;
      end
   end

   // held sequence bytes, no reset
   always_ff @(posedge clock) begin
      if (accept && held_we)
         held_ff[held_idx] <= b;
   end

endmodule

[rtl/core/usl_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser burst queue
// Short first-in first-out store of burst words between front and back.
// ----------------------------------------------------------------------------
module usl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  usl_pkg::usl_desc_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output usl_pkg::usl_desc_type head
);
   import usl_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   usl_desc_type    mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PtrW+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // pointer and fill updates
   always_comb begin
      wr_in  = push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ff] <= push_data;
   end

endmodule

[rtl/core/usl_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser back end
// Unpacks each burst word into single result words behind an output register.
// ----------------------------------------------------------------------------
module usl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  usl_pkg::usl_desc_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output usl_pkg::usl_rsp_type  rsp_data
);
   import usl_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   usl_rsp_type data_ff, data_in;
   logic        load;
   logic        last;

   assign load = !q_empty && (!valid_ff || rsp_ready);
   assign last = ({1'b0, idx_ff} + 3'd1 == q_head.count);

   // next result word
   always_comb begin
      q_pop   = load && last;
      idx_in  = idx_ff;
      data_in = data_ff;
      if (load) begin
         idx_in                 = last ? 2'd0 : idx_ff + 2'd1;
         data_in.out_byte       = q_head.bytes[idx_ff];
         data_in.byte_valid     = q_head.byte_valid;
         data_in.run_last       = last;
         data_in.text_done      = last && q_head.string_end;
         data_in.non_ascii_seen = last && q_head.string_end && q_head.non_ascii;
      end
      if (load)
         valid_in = 1'b1;
      else if (rsp_ready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[rtl/core/utf8_sanitize_latin_fold.sv]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser with Latin-1 fold
// Streaming UTF-8 cleaner: bad bytes become '?', optional accent fold and
// optional per-string codepoint clip.
// ----------------------------------------------------------------------------
//  port group | direction | word                 | handshake
//  req_*      | in        | byte + string end    | req_valid / req_ready
//  rsp_*      | out       | one result byte      | rsp_valid / rsp_ready
//  csr_*      | in        | index + write data   | csr_valid / csr_ready
//
//  A byte is taken every cycle while the four-word burst queue has room.
//  Each byte yields 0 to 4 results; the back end sends one per cycle while
//  rsp_ready is high, so the sustained rate is one byte per cycle while bursts
//  stay at one result. Results pass the queue, then the back end's output register.
//  Synchronous reset clears sequence state, counters and the queue.
//  Either side may stall freely; the queue decouples them.
// ----------------------------------------------------------------------------
module utf8_sanitize_latin_fold (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  usl_pkg::usl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output usl_pkg::usl_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import usl_pkg::*;

   usl_cfg_type  cfg_ff, cfg_in;
   logic         q_full;
   logic         q_push;
   usl_desc_type q_wdata;
   logic         q_pop;
   logic         q_empty;
   usl_desc_type q_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FOLD_MODE:   cfg_in.fold_mode   = csr_wdata[0];
            CSR_CLIP_ENABLE: cfg_in.clip_enable = csr_wdata[0];
            CSR_CLIP_LIMIT:  cfg_in.clip_limit  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fold_mode   <= 1'b0;
         cfg_ff.clip_enable <= 1'b0;
         cfg_ff.clip_limit  <= CLIP_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   usl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   usl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   usl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/usl_checker.sv]
// ----------------------------------------------------------------------------
// UTF-8 sanitiser port checker
// Watches the top-level ports for result word consistency over time.
// ----------------------------------------------------------------------------
`include "utf8_sanitize_latin_fold_macros.svh"

module usl_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input usl_pkg::usl_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input usl_pkg::usl_rsp_type rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [1:0]           csr_index,
   input logic [15:0]          csr_wdata
);
   import usl_pkg::*;

   // a stalled result word holds
   `USL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // string end only closes a burst
   `USL_ASSERT_IMPLY(a_done_last, rsp_valid && rsp_data.text_done, rsp_data.run_last)

   // multibyte report only at string end
   `USL_ASSERT_IMPLY(a_flag_done, rsp_valid && rsp_data.non_ascii_seen, rsp_data.text_done)

   // a bare marker is a lone zero word ending the string
   `USL_ASSERT_IMPLY(a_bare_marker, rsp_valid && !rsp_data.byte_valid, rsp_data.text_done && rsp_data.out_byte == 8'h00)

endmodule

bind utf8_sanitize_latin_fold usl_checker u_checker (.*);
